[rtl/core/iff_pkg.sv]
// Shared constants, conversion codes and the digit-to-ASCII function for the field formatter.
package iff_pkg;

    // Default cap on the field width.
    localparam int MAX_FIELD_WIDTH_DEF = 63;

    // Conversion codes carried in the opcode field.
    localparam logic [2:0] OP_SDEC = 3'd0;
    localparam logic [2:0] OP_UDEC = 3'd1;
    localparam logic [2:0] OP_HEXL = 3'd2;
    localparam logic [2:0] OP_HEXU = 3'd3;
    localparam logic [2:0] OP_OCT  = 3'd4;
    localparam logic [2:0] OP_PTR  = 3'd5;

    // Digit store: enough for 22 octal digits of a 64-bit value.
    localparam int DIGITS    = 22;
    localparam int DIG_IDX_W = 5;
    // BCD digits needed for any 64-bit unsigned value.
    localparam int BCD_DIGITS = 20;

    // ASCII characters used in the field.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    // Map one digit value to its ASCII character.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        begin
            base = upper ? CH_UA : CH_LA;
            if (d < 4'd10) begin
                digit_char = CH_ZERO + {4'b0, d};
            end else begin
                digit_char = base + {4'b0, d} - 8'd10;
            end
        end
    endfunction

endpackage

[rtl/core/integer_field_formatter.sv]
// Top level of the printf-style integer field formatter with a decimal shift unit.
// Flow: one item is taken, then decimal conversions pass through the shift-and-adjust
// (double-dabble) loop, while hex, octal and pointer skip it; a state finds the digit
// count, then one character leaves per cycle while the consumer does not stall. A new
// item is taken only after the last character of the field has been loaded.
// Reset (synchronous, active low) returns the sequencer to idle and drops the output valid.
module integer_field_formatter #(
    parameter int MAX_FIELD_WIDTH = iff_pkg::MAX_FIELD_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata, low bit up: operand_value[63:0], field_width[69:64], zero_fill[70], zeros.
    input  logic [71:0] s_axis_tdata,
    // tuser, low bit up: opcode[2:0], operand_wide[3].
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_char[7:0].
    output logic [7:0]  m_axis_tdata,
    // tlast: last_char.
    output logic        m_axis_tlast
);

    localparam int CW = $clog2(MAX_FIELD_WIDTH + 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DABBLE = 2'd1;
    localparam logic [1:0] ST_LEN    = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    logic [1:0]  state_reg, state_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] mag_reg, mag_next;
    logic [iff_pkg::DIGITS-1:0][3:0] dig_reg, dig_next;
    logic        upper_reg, upper_next;
    logic        ptr_reg, ptr_next;
    logic        zfill_reg, zfill_next;
    logic [1:0]  plen_reg, plen_next;
    logic [CW-1:0] width_reg, width_next;
    logic [CW-1:0] pad_reg, pad_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_data_reg, m_data_next;
    logic        m_last_reg, m_last_next;

    // Input field views.
    logic [2:0]  in_op;
    logic        in_wide;
    logic [63:0] in_val;
    logic [5:0]  in_width;
    logic        in_zfill;
    logic        accept;

    assign in_op    = s_axis_tuser[2:0];
    assign in_wide  = s_axis_tuser[3];
    assign in_val   = s_axis_tdata[63:0];
    assign in_width = s_axis_tdata[69:64];
    assign in_zfill = s_axis_tdata[70];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    // Operand preparation: size selection, sign extension and magnitude.
    logic [63:0] val_sized, val_sext, mag_in;
    logic [65:0] oct_ext;
    logic        neg_in;
    logic [6:0]  width_cap;

    always_comb begin
        val_sized = (in_op != iff_pkg::OP_PTR && !in_wide) ? {32'b0, in_val[31:0]} : in_val;
        val_sext  = (in_op == iff_pkg::OP_SDEC && !in_wide)
                  ? {{32{val_sized[31]}}, val_sized[31:0]} : val_sized;
        neg_in    = (in_op == iff_pkg::OP_SDEC) && val_sext[63];
        mag_in    = neg_in ? (64'd0 - val_sext) : val_sext;
        oct_ext   = {2'b00, mag_in};
        width_cap = ({1'b0, in_width} > 7'(MAX_FIELD_WIDTH))
                  ? 7'(MAX_FIELD_WIDTH) : {1'b0, in_width};
    end

    // One double-dabble step: adjust every BCD digit, then shift the pair left.
    logic [79:0] bcd_adj;
    logic [3:0]  bcd_d;

    always_comb begin
        bcd_adj = '0;
        for (int i = 0; i < iff_pkg::BCD_DIGITS; i++) begin
            bcd_d = dig_reg[i];
            bcd_adj[4*i +: 4] = (bcd_d >= 4'd5) ? bcd_d + 4'd3 : bcd_d;
        end
    end

    // Digit count: position of the highest nonzero digit, at least one.
    logic [4:0] dlen;
    logic [4:0] body;
    logic [6:0] body7, wreg7;

    always_comb begin
        dlen = 5'd1;
        for (int i = 0; i < iff_pkg::DIGITS; i++) begin
            if (dig_reg[i] != 4'd0) begin
                dlen = 5'(i + 1);
            end
        end
        body  = {3'b0, plen_reg} + dlen;
        body7 = {2'b0, body};
        wreg7 = 7'(width_reg);
    end

    // Character at the current field position.
    localparam int DIG_IDX_W_L = iff_pkg::DIG_IDX_W;
    logic [CW-1:0] plen_ext, pp_end;
    logic [CW-1:0] pre_off;
    logic [DIG_IDX_W_L-1:0] dig_idx;
    logic [7:0]    pre_char, cur_char;
    logic          in_digits;

    always_comb begin
        plen_ext  = CW'(plen_reg);
        pp_end    = pad_reg + plen_ext;
        pre_off   = zfill_reg ? pos_reg : (pos_reg - pad_reg);
        pre_char  = ptr_reg ? (pre_off[0] ? iff_pkg::CH_X : iff_pkg::CH_ZERO) : iff_pkg::CH_MINUS;
        dig_idx   = DIG_IDX_W_L'(total_reg - pos_reg - CW'(1));
        in_digits = (pos_reg >= pp_end);
        if (in_digits) begin
            cur_char = iff_pkg::digit_char(dig_reg[dig_idx], upper_reg);
        end else if (!zfill_reg) begin
            cur_char = (pos_reg < pad_reg) ? iff_pkg::CH_SPACE : pre_char;
        end else begin
            cur_char = (pos_reg < plen_ext) ? pre_char : iff_pkg::CH_ZERO;
        end
    end

    // Sequencer and datapath next-state logic.
    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        mag_next     = mag_reg;
        dig_next     = dig_reg;
        upper_next   = upper_reg;
        ptr_next     = ptr_reg;
        zfill_next   = zfill_reg;
        plen_next    = plen_reg;
        width_next   = width_reg;
        pad_next     = pad_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        // The result stage drains whenever the consumer takes a transaction.
        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && in_op <= iff_pkg::OP_PTR) begin
                    upper_next = (in_op == iff_pkg::OP_HEXU);
                    ptr_next   = (in_op == iff_pkg::OP_PTR);
                    zfill_next = in_zfill;
                    plen_next  = (in_op == iff_pkg::OP_PTR) ? 2'd2 : {1'b0, neg_in};
                    width_next = CW'(width_cap);
                    mag_next   = mag_in;
                    cnt_next   = '0;
                    if (in_op == iff_pkg::OP_SDEC || in_op == iff_pkg::OP_UDEC) begin
                        dig_next   = '0;
                        state_next = ST_DABBLE;
                    end else if (in_op == iff_pkg::OP_OCT) begin
                        for (int i = 0; i < iff_pkg::DIGITS; i++) begin
                            dig_next[i] = {1'b0, oct_ext[3*i +: 3]};
                        end
                        state_next = ST_LEN;
                    end else begin
                        dig_next   = {24'b0, mag_in};
                        state_next = ST_LEN;
                    end
                end
            end
            ST_DABBLE: begin
                dig_next = {8'b0, bcd_adj[78:0], mag_reg[63]};
                mag_next = {mag_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                if (wreg7 > body7) begin
                    pad_next   = CW'(wreg7 - body7);
                    total_next = width_reg;
                end else begin
                    pad_next   = '0;
                    total_next = CW'(body7);
                end
                pos_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                // Load the next character once the result stage is free.
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = cur_char;
                    m_last_next  = (pos_reg == total_reg - CW'(1));
                    pos_next     = pos_reg + CW'(1);
                    if (pos_reg == total_reg - CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers take reset; payload registers do not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        cnt_reg    <= cnt_next;
        mag_reg    <= mag_next;
        dig_reg    <= dig_next;
        upper_reg  <= upper_next;
        ptr_reg    <= ptr_next;
        zfill_reg  <= zfill_next;
        plen_reg   <= plen_next;
        width_reg  <= width_next;
        pad_reg    <= pad_next;
        total_reg  <= total_next;
        pos_reg    <= pos_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

endmodule
